/* rtl/bsmm_pkg.sv */
// shared types and constants for the bank-switched memory mapper
package bsmm_pkg;

  typedef enum logic [2:0] {
    MODE_MEM_RD = 3'd0,
    MODE_MEM_WR = 3'd1,
    MODE_IO_RD  = 3'd2,
    MODE_IO_WR  = 3'd3,
    MODE_DMA_RD = 3'd4,
    MODE_DMA_WR = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    RG_NONE  = 4'd0,
    RG_RAM   = 4'd1,
    RG_VRAM  = 4'd2,
    RG_TVRAM = 4'd3,
    RG_PCG   = 4'd4,
    RG_IPL   = 4'd5,
    RG_KANJI = 4'd6,
    RG_DIC   = 4'd7,
    RG_EXT   = 4'd8,
    RG_CRTC  = 4'd9
  } region_t;

  typedef enum logic [1:0] {
    LCM_IPL   = 2'd0,
    LCM_PCG   = 2'd1,
    LCM_KANJI = 2'd2
  } lcm_t;

  typedef struct packed {
    logic [5:0] window_base;
    logic [7:0] vram_ctl;
    logic [7:0] dict_bank;
    logic [7:0] font_bank;
    logic [1:0] vram_plane;
    logic       text_remap;
    logic [1:0] low_char_mode;
  } bsmm_state_t;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned OFFSET_W = 23;
  localparam int unsigned PORT_W   = 15;

  localparam logic [PORT_W-1:0] PORT_WINDOW = 15'h008c;
  localparam logic [PORT_W-1:0] PORT_VRAM   = 15'h008d;
  localparam logic [PORT_W-1:0] PORT_DICT   = 15'h00ce;
  localparam logic [PORT_W-1:0] PORT_KANJI  = 15'h0274;

  localparam logic [5:0] WINDOW_TAG = 6'h02;
  localparam logic [6:0] CRTC_TAG   = 7'h06;
  localparam logic [5:0] WINDOW_RST = 6'h02;

  localparam logic [ADDR_W-1:0] VRAM_START  = 24'h0c0000;
  localparam logic [ADDR_W-1:0] DIC_START   = 24'h0e0000;
  localparam logic [ADDR_W-1:0] LOW_START   = 24'h0f0000;
  localparam logic [ADDR_W-1:0] PCG_START   = 24'h0f1000;
  localparam logic [ADDR_W-1:0] TVRAM_START = 24'h0f4000;
  localparam logic [ADDR_W-1:0] IPL_START   = 24'h0f8000;
  localparam logic [ADDR_W-1:0] GAP_START   = 24'h100000;
  localparam logic [ADDR_W-1:0] EXT_START   = 24'h200000;
  localparam logic [ADDR_W-1:0] EXT_END     = 24'h800000;
  localparam logic [ADDR_W-1:0] HIGH_IPL    = 24'hff0000;

  localparam logic [7:0] IO_UNMAPPED = 8'hff;

endpackage

/* rtl/bsmm_regs.sv */
// i/o register file: window, vram, dictionary and kanji bank registers
module bsmm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bsmm_pkg::PORT_W-1:0]    port,
  input  logic [7:0]                     wr_data,
  output bsmm_pkg::bsmm_state_t          state,
  output logic [7:0]                     rd_data
);

  bsmm_pkg::bsmm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (wr_en) begin
      priority if (port == bsmm_pkg::PORT_WINDOW) begin
        state_nxt.window_base = wr_data[5:0];
      end else if (port == bsmm_pkg::PORT_VRAM) begin
        state_nxt.vram_ctl = wr_data;
        if (wr_data == 8'd0) begin
          state_nxt.text_remap    = 1'b1;
          state_nxt.low_char_mode = state_r.font_bank[7] ? bsmm_pkg::LCM_KANJI
                                                         : bsmm_pkg::LCM_PCG;
        end else if (wr_data[7:2] == 6'd1) begin
          state_nxt.vram_plane = wr_data[1:0];
        end
      end else if (port == bsmm_pkg::PORT_DICT) begin
        state_nxt.dict_bank = wr_data;
      end else if (port == bsmm_pkg::PORT_KANJI) begin
        state_nxt.font_bank     = wr_data;
        state_nxt.low_char_mode = wr_data[7] ? bsmm_pkg::LCM_KANJI : bsmm_pkg::LCM_PCG;
      end else begin
        state_nxt = state_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.window_base   <= bsmm_pkg::WINDOW_RST;
      state_r.vram_ctl      <= 8'd0;
      state_r.dict_bank     <= 8'd0;
      state_r.font_bank     <= 8'd0;
      state_r.vram_plane    <= 2'd0;
      state_r.text_remap    <= 1'b0;
      state_r.low_char_mode <= bsmm_pkg::LCM_IPL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    priority if (port == bsmm_pkg::PORT_WINDOW) begin
      rd_data = {2'b00, state_r.window_base};
    end else if (port == bsmm_pkg::PORT_VRAM) begin
      rd_data = state_r.vram_ctl;
    end else if (port == bsmm_pkg::PORT_DICT) begin
      rd_data = state_r.dict_bank;
    end else if (port == bsmm_pkg::PORT_KANJI) begin
      rd_data = state_r.font_bank;
    end else begin
      rd_data = bsmm_pkg::IO_UNMAPPED;
    end
  end

  assign state = state_r;

endmodule

/* rtl/bsmm_decode.sv */
// address decoder: window redirect, crtc hole and region/offset lookup
module bsmm_decode (
  input  logic [2:0]                      mode,
  input  logic [bsmm_pkg::ADDR_W-1:0]     address,
  input  bsmm_pkg::bsmm_state_t           state,
  output logic [3:0]                      region,
  output logic [bsmm_pkg::OFFSET_W-1:0]   region_offset
);

  logic                          is_cpu;
  logic                          is_dma;
  logic                          wr;
  logic                          rd_alt;
  logic                          crtc;
  logic [bsmm_pkg::ADDR_W-1:0]   a;
  bsmm_pkg::region_t             rg;
  logic [bsmm_pkg::OFFSET_W-1:0] off;

  always_comb begin
    is_cpu = (mode == bsmm_pkg::MODE_MEM_RD) || (mode == bsmm_pkg::MODE_MEM_WR);
    is_dma = (mode == bsmm_pkg::MODE_DMA_RD) || (mode == bsmm_pkg::MODE_DMA_WR);
    wr     = (mode == bsmm_pkg::MODE_MEM_WR) || (mode == bsmm_pkg::MODE_DMA_WR);
    rd_alt = wr || state.text_remap;
    a      = address;
    if (is_cpu && (address[23:18] == bsmm_pkg::WINDOW_TAG)) begin
      a = {state.window_base, address[17:0]};
    end
    crtc = is_cpu && (address[23:17] == bsmm_pkg::CRTC_TAG) && (state.vram_ctl == 8'd0);

    rg  = bsmm_pkg::RG_NONE;
    off = '0;
    priority if (crtc) begin
      rg  = bsmm_pkg::RG_CRTC;
      off = address[bsmm_pkg::OFFSET_W-1:0];
    end else if (!(is_cpu || is_dma)) begin
      rg  = bsmm_pkg::RG_NONE;
    end else if (a < bsmm_pkg::VRAM_START) begin
      rg  = bsmm_pkg::RG_RAM;
      off = a[bsmm_pkg::OFFSET_W-1:0];
    end else if (a < bsmm_pkg::DIC_START) begin
      rg  = bsmm_pkg::RG_VRAM;
      off = 23'({state.vram_plane, a[16:0]});
    end else if (a < bsmm_pkg::LOW_START) begin
      if (!wr) begin
        rg  = bsmm_pkg::RG_DIC;
        off = 23'({state.dict_bank[4:3], a[15:0]});
      end
    end else if (a < bsmm_pkg::PCG_START) begin
      if (state.low_char_mode == bsmm_pkg::LCM_KANJI) begin
        if (!wr) begin
          rg  = bsmm_pkg::RG_KANJI;
          off = 23'({state.font_bank[6:0], a[11:0]});
        end
      end else if (wr || (state.low_char_mode == bsmm_pkg::LCM_PCG)) begin
        rg  = bsmm_pkg::RG_PCG;
        off = 23'(a[15:0]);
      end else begin
        rg  = bsmm_pkg::RG_IPL;
        off = 23'(a[15:0]);
      end
    end else if (a < bsmm_pkg::TVRAM_START) begin
      rg  = rd_alt ? bsmm_pkg::RG_PCG : bsmm_pkg::RG_IPL;
      off = 23'(a[15:0]);
    end else if (a < bsmm_pkg::IPL_START) begin
      if (rd_alt) begin
        rg  = bsmm_pkg::RG_TVRAM;
        off = 23'(a[12:0]);
      end else begin
        rg  = bsmm_pkg::RG_IPL;
        off = 23'(a[15:0]);
      end
    end else if (a < bsmm_pkg::GAP_START) begin
      if (!wr) begin
        rg  = bsmm_pkg::RG_IPL;
        off = 23'(a[15:0]);
      end
    end else if (a < bsmm_pkg::EXT_START) begin
      rg  = bsmm_pkg::RG_NONE;
    end else if (a < bsmm_pkg::EXT_END) begin
      rg  = bsmm_pkg::RG_EXT;
      off = 23'(a - bsmm_pkg::EXT_START);
    end else if (a >= bsmm_pkg::HIGH_IPL) begin
      if (!wr) begin
        rg  = bsmm_pkg::RG_IPL;
        off = 23'(a[15:0]);
      end
    end else begin
      rg  = bsmm_pkg::RG_NONE;
    end
  end

  assign region        = rg;
  assign region_offset = off;

endmodule

/* rtl/bank_switched_memory_mapper_top.sv */
// top level: input register, decode and i/o registers, output register
// throughput: one transaction per cycle while out_tready holds, set by the input and output registers
// an i/o write updates the registers as it moves to the output register,
// so the next transaction already decodes against the new values
// reset: synchronous active-low rst_n empties both stages and restores registers
module bank_switched_memory_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[2:0], address[26:3], write_data[34:27], zero[39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // region[3:0], region_offset[26:4], io_read_data[34:27], zero[39:35]
);

  logic                           s1_valid_r;
  logic [2:0]                     s1_mode_r;
  logic [bsmm_pkg::ADDR_W-1:0]    s1_addr_r;
  logic [7:0]                     s1_data_r;

  logic                           out_valid_r;
  logic [3:0]                     out_region_r;
  logic [bsmm_pkg::OFFSET_W-1:0]  out_offset_r;
  logic [7:0]                     out_iod_r;

  logic                           adv;
  logic                           io_wr;
  logic                           io_rd;
  bsmm_pkg::bsmm_state_t          state;
  logic [7:0]                     rd_data;
  logic [3:0]                     dec_region;
  logic [bsmm_pkg::OFFSET_W-1:0]  dec_offset;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign io_wr     = (s1_mode_r == bsmm_pkg::MODE_IO_WR);
  assign io_rd     = (s1_mode_r == bsmm_pkg::MODE_IO_RD);

  bsmm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adv && io_wr),
    .port    (s1_addr_r[bsmm_pkg::PORT_W-1:0]),
    .wr_data (s1_data_r),
    .state   (state),
    .rd_data (rd_data)
  );

  bsmm_decode u_decode (
    .mode          (s1_mode_r),
    .address       (s1_addr_r),
    .state         (state),
    .region        (dec_region),
    .region_offset (dec_offset)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tdata[2:0];
      s1_addr_r <= in_tdata[26:3];
      s1_data_r <= in_tdata[34:27];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_region_r <= dec_region;
      out_offset_r <= dec_offset;
      out_iod_r    <= io_rd ? rd_data : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_iod_r, out_offset_r, out_region_r};

endmodule

/* rtl/bsmm_checker.sv */
// port-level checker for the memory mapper top level, with its bind
module bsmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic [3:0]  chk_region;
  logic [22:0] chk_offset;
  logic [7:0]  chk_iod;

  assign chk_region = out_tdata[3:0];
  assign chk_offset = out_tdata[26:4];
  assign chk_iod    = out_tdata[34:27];

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // no region code past crtc
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_region <= bsmm_pkg::RG_CRTC)
    else $error("region code out of range");

  // an unmapped or i/o result carries a zero offset
  a_none_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_region == bsmm_pkg::RG_NONE |-> chk_offset == 23'd0)
    else $error("offset set without a region");

  // i/o read data only appears without a region
  a_iod_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_iod != 8'd0 |-> chk_region == bsmm_pkg::RG_NONE)
    else $error("i/o data on a memory transaction");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind bank_switched_memory_mapper_top bsmm_checker u_bsmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
